[hw/rtl/mkd_pkg.sv]
`default_nettype none
package mkd_pkg;

  localparam int ROWS    = 4;
  localparam int COLS    = 4;
  localparam int KEYS    = ROWS * COLS;
  localparam int FIELD_W = 16;
  localparam int CNT_W   = 3;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [CNT_W-1:0]   ROWS_RST   = CNT_W'(4);
  localparam logic [CNT_W-1:0]   COLS_RST   = CNT_W'(4);
  localparam logic [FIELD_W-1:0] ENABLE_RST = '1;

  typedef enum logic [1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_ENABLE = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef logic [KEYS-1:0] key_vec_t;

  // control into the key bank
  typedef struct packed {
    logic     upd;
    key_vec_t area;
  } bank_ctl_t;

  // flags out of the key bank: current and after this scan
  typedef struct packed {
    key_vec_t tent;
    key_vec_t stable;
    key_vec_t stable_nxt;
    key_vec_t edge_nxt;
  } bank_sts_t;

  // keys inside the scanned rectangle; counts above ROWS/COLS saturate naturally
  function automatic key_vec_t key_area(logic [CNT_W-1:0] rows, logic [CNT_W-1:0] cols);
    key_vec_t m;
    m = '0;
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        m[r*COLS+c] = (r < int'(rows)) && (c < int'(cols));
      end
    end
    return m;
  endfunction

  // map key vector onto the 16-bit field, dropping keys past the field
  function automatic logic [FIELD_W-1:0] to_field(key_vec_t v);
    logic [KEYS+FIELD_W-1:0] pad;
    pad = {{FIELD_W{1'b0}}, v};
    return pad[FIELD_W-1:0];
  endfunction

  // keys past the field read as open
  function automatic key_vec_t from_field(logic [FIELD_W-1:0] f);
    logic [KEYS+FIELD_W-1:0] pad;
    pad = {{KEYS{1'b1}}, f};
    return pad[KEYS-1:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/mkd_key_bank.sv]
`default_nettype none
module mkd_key_bank (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mkd_pkg::bank_ctl_t ctl,
  input  wire mkd_pkg::key_vec_t  levels,
  output mkd_pkg::bank_sts_t      sts
);

  mkd_pkg::key_vec_t tent_r, stable_r, edge_r;
  mkd_pkg::key_vec_t tent_nxt, stable_nxt, edge_nxt;
  mkd_pkg::key_vec_t closed, t_calc, s_calc, e_calc;

  always_comb begin
    closed = ~levels;
    // two equal samples confirm; a stable key that reads open drops to tentative
    s_calc = closed & (stable_r | tent_r);
    e_calc = ~stable_r & tent_r;
    t_calc = (closed & ~stable_r & ~tent_r) | (~closed & stable_r);
    tent_nxt   = tent_r;
    stable_nxt = stable_r;
    edge_nxt   = edge_r;
    if (ctl.upd) begin
      tent_nxt   = (t_calc & ctl.area) | (tent_r & ~ctl.area);
      stable_nxt = (s_calc & ctl.area) | (stable_r & ~ctl.area);
      edge_nxt   = (e_calc & ctl.area) | (edge_r & ~ctl.area);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tent_r   <= '0;
      stable_r <= '0;
      edge_r   <= '0;
    end else begin
      tent_r   <= tent_nxt;
      stable_r <= stable_nxt;
      edge_r   <= edge_nxt;
    end
  end

  assign sts.tent       = tent_r;
  assign sts.stable     = stable_r;
  assign sts.stable_nxt = stable_nxt;
  assign sts.edge_nxt   = edge_nxt;

endmodule
`default_nettype wire

[hw/rtl/matrix_keypad_debounce.sv]
`default_nettype none
// A scan accepted at a clock edge has its result on out_* from the next cycle.
// Throughput: one scan per cycle; the key flags and the result register both update
// at the accepting edge, and in_stall rises only while a result waits under out_stall.
// Reset (rst_n, synchronous, active low): all key flags released, no result pending,
// valid_rows = 4, valid_cols = 4, event_enable = 0xFFFF.
module matrix_keypad_debounce (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [mkd_pkg::FIELD_W-1:0]  in_key_levels,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mkd_pkg::FIELD_W-1:0]       out_edge_mask,
  output logic [mkd_pkg::FIELD_W-1:0]       out_stable_mask,
  output logic                              out_any_edge,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [mkd_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [mkd_pkg::DATA_W-1:0]   pwdata,
  output logic [mkd_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  logic [mkd_pkg::CNT_W-1:0]   valid_rows_r, valid_cols_r;
  logic [mkd_pkg::FIELD_W-1:0] event_enable_r;
  logic                        out_valid_r;
  logic [mkd_pkg::FIELD_W-1:0] edge_r, stable_r;
  logic                        any_r;
  logic [mkd_pkg::FIELD_W-1:0] edge_nxt;

  mkd_pkg::reg_idx_t  reg_idx;
  mkd_pkg::bank_ctl_t bank_ctl;
  mkd_pkg::bank_sts_t bank_sts;
  logic               in_fire, cfg_wr;

  assign pready   = 1'b1;
  assign reg_idx  = mkd_pkg::reg_idx_t'(paddr[mkd_pkg::ADDR_W-1:2]);
  assign cfg_wr   = psel && penable && pwrite;
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_rows_r   <= mkd_pkg::ROWS_RST;
      valid_cols_r   <= mkd_pkg::COLS_RST;
      event_enable_r <= mkd_pkg::ENABLE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        mkd_pkg::REG_ROWS:   valid_rows_r   <= pwdata[mkd_pkg::CNT_W-1:0];
        mkd_pkg::REG_COLS:   valid_cols_r   <= pwdata[mkd_pkg::CNT_W-1:0];
        mkd_pkg::REG_ENABLE: event_enable_r <= pwdata[mkd_pkg::FIELD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mkd_pkg::REG_ROWS:   prdata = mkd_pkg::DATA_W'(valid_rows_r);
      mkd_pkg::REG_COLS:   prdata = mkd_pkg::DATA_W'(valid_cols_r);
      mkd_pkg::REG_ENABLE: prdata = mkd_pkg::DATA_W'(event_enable_r);
      default:             prdata = '0;
    endcase
  end

  assign bank_ctl.upd  = in_fire;
  assign bank_ctl.area = mkd_pkg::key_area(valid_rows_r, valid_cols_r);

  mkd_key_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (bank_ctl),
    .levels (mkd_pkg::from_field(in_key_levels)),
    .sts    (bank_sts)
  );

  assign edge_nxt = mkd_pkg::to_field(bank_sts.edge_nxt) & event_enable_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload loads with each accepted transaction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      edge_r   <= edge_nxt;
      stable_r <= mkd_pkg::to_field(bank_sts.stable_nxt);
      any_r    <= |edge_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_edge_mask   = edge_r;
  assign out_stable_mask = stable_r;
  assign out_any_edge    = any_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted scan produced no result");

  a_any_edge_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (any_r == (edge_r != '0)))
    else $error("any_edge disagrees with edge mask");

  a_tent_stable_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_sts.tent & bank_sts.stable) == '0)
    else $error("key both tentative and stable");

  a_flags_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(bank_sts.stable))
    else $error("key flags changed without a scan");

endmodule
`default_nettype wire
